FILE: rtl/pidm_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the derivative-on-measurement PID block.
// No dependencies.
`default_nettype none

package pidm_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam int CFG_W    = 16;   // gain and period register width
  localparam int DATA_W   = 32;   // widest register, output width
  localparam int INTEG_W  = 48;
  localparam int OUT_FRAC = 8;
  localparam int TIME_W   = 32;
  localparam int IDX_W    = 3;

  localparam logic [CFG_W-1:0] MS_PER_S     = 16'd1000;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd100;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [IDX_W-1:0] REG_PERIOD     = 3'd3;
  localparam logic [IDX_W-1:0] REG_START_OUT  = 3'd4;

endpackage

`default_nettype wire

FILE: rtl/pidm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and results.
// Depends on pidm_pkg.
`default_nettype none

interface pidm_item_if
  import pidm_pkg::*;
#(parameter int SAMPLE_BITS = SAMPLE_BITS_DEF) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] target;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic [TIME_W-1:0]             time_ms;

  modport source(output valid, target, sample, time_ms, input ready);
  modport sink(input valid, target, sample, time_ms, output ready);
endinterface

interface pidm_result_if
  import pidm_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] drive;
  logic                     updated;

  modport source(output valid, drive, updated, input ready);
  modport sink(input valid, drive, updated, output ready);
endinterface

`default_nettype wire

FILE: rtl/pidm_mul.sv
`timescale 1ns / 1ps
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
// Depends on pidm_pkg.
`default_nettype none

module pidm_mul
  import pidm_pkg::*;
#(
  parameter int AW = 33,
  parameter int BW = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic                  done,
  output logic [AW+BW-1:0]      prod
);

  localparam int CW = $clog2(BW);

  logic [AW-1:0] areg;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [AW:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, areg} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        areg <= a;
        hi   <= '0;
        lo   <= b;
        cnt  <= CW'(BW - 1);
      end else if (busy) begin
        hi  <= sum[AW:1];
        lo  <= {sum[0], lo[BW-1:1]};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pidm_div.sv
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on pidm_pkg.
`default_nettype none

module pidm_div
  import pidm_pkg::*;
#(
  parameter int NW = 57,
  parameter int DW = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quo,
  output logic               rem_nz
);

  localparam int CW = $clog2(NW);

  logic [DW-1:0] dreg;
  logic [DW-1:0] rem;
  logic [NW-1:0] q;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   shifted;
  logic [DW:0]   trial;
  logic          fits;

  assign shifted = {rem, q[NW-1]};
  assign trial   = shifted - {1'b0, dreg};
  assign fits    = shifted >= {1'b0, dreg};
  assign quo     = q;
  assign rem_nz  = |rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        dreg <= den;
        rem  <= '0;
        q    <= num;
        cnt  <= CW'(NW - 1);
      end else if (busy) begin
        rem <= fits ? trial[DW-1:0] : shifted[DW-1:0];
        q   <= {q[NW-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pid_derivative_on_measurement_top.sv
`timescale 1ns / 1ps
// Top level: PID controller with derivative on measurement, bit-serial datapath.
// Depends on pidm_pkg, pidm_if, pidm_mul, pidm_div.
// One item at a time. An item inside the sample period goes from the transfer
// straight to the DONE state, which loads the output register. An update runs five
// 16-bit serial multiplies and up to two restoring divides (the derivative divide is
// skipped at zero elapsed time), plus the transfer, sum and output steps; the
// serial multiplier and divider set its length. A finished result sits in the
// output register and the next item is taken while it waits.
`default_nettype none

module pid_derivative_on_measurement_top
  import pidm_pkg::*;
#(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  wire logic [IDX_W-1:0]  wr_index,
  input  wire logic [DATA_W-1:0] wr_data,
  pidm_item_if.sink              item,
  pidm_result_if.source          result
);

  localparam int S  = SAMPLE_BITS;
  localparam int AW = S + 1 + CFG_W;
  localparam int PW = AW + CFG_W;
  localparam int NW = PW + OUT_FRAC;
  localparam int SW = NW + 3;

  localparam logic signed [SW-1:0] I_HI = $signed({{(SW-INTEG_W+1){1'b0}}, {(INTEG_W-1){1'b1}}});
  localparam logic signed [SW-1:0] I_LO = $signed({{(SW-INTEG_W+1){1'b1}}, {(INTEG_W-1){1'b0}}});
  localparam logic signed [SW-1:0] O_HI = $signed({{(SW-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}});
  localparam logic signed [SW-1:0] O_LO = $signed({{(SW-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}});

  typedef enum logic [3:0] {
    IDLE, P_MUL, I_MUL1, I_MUL2, I_DIV, D_MUL1, D_MUL2, D_DIV, SUM, DONE
  } state_t;

  state_t st;

  // configuration
  logic [CFG_W-1:0]  prop_gain, integ_gain, deriv_gain, period;
  logic [DATA_W-1:0] start_output;

  // controller state
  logic signed [DATA_W-1:0]  held_output;
  logic signed [INTEG_W-1:0] integrator;
  logic signed [S-1:0]       prev_sample;
  logic [TIME_W-1:0]         prev_time;
  logic                      primed;

  // per-item work registers
  logic [S:0]            err_mag, dm_mag;
  logic                  err_neg, dm_neg;
  logic [CFG_W-1:0]      elapsed;
  logic [TIME_W-1:0]     now_t;
  logic signed [S-1:0]   meas;
  logic signed [SW-1:0]  p_term, d_term;
  logic                  upd_flag;
  logic signed [DATA_W-1:0] out_drive;
  logic                  out_updated;

  // serial units
  logic              mul_go, mul_done;
  logic [AW-1:0]     mul_a;
  logic [CFG_W-1:0]  mul_b;
  logic [PW-1:0]     mul_p;
  logic              div_go, div_done, div_rnz;
  logic [NW-1:0]     div_n, div_q;
  logic [CFG_W-1:0]  div_d;

  pidm_mul #(.AW(AW), .BW(CFG_W)) u_mul (
    .clk(clk), .rst(rst), .start(mul_go), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(mul_p)
  );

  pidm_div #(.NW(NW), .DW(CFG_W)) u_div (
    .clk(clk), .rst(rst), .start(div_go), .num(div_n), .den(div_d),
    .done(div_done), .quo(div_q), .rem_nz(div_rnz)
  );

  // elapsed time and error terms of the offered item
  logic [TIME_W-1:0]  diff;
  logic [CFG_W-1:0]   el_c;
  logic signed [S:0]  err_c, dm_c;

  assign diff  = item.time_ms - prev_time;
  assign el_c  = !primed ? period :
                 (|diff[TIME_W-1:CFG_W]) ? {CFG_W{1'b1}} : diff[CFG_W-1:0];
  assign err_c = {item.target[S-1], item.target} - {item.sample[S-1], item.sample};
  assign dm_c  = {item.sample[S-1], item.sample} - {prev_sample[S-1], prev_sample};

  assign item.ready     = (st == IDLE);
  assign result.drive   = out_drive;
  assign result.updated = out_updated;

  function automatic logic signed [SW-1:0] apply_sign(logic [SW-1:0] mag, logic neg);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [SW-1:0] floor_quo(logic [NW-1:0] q, logic rnz, logic neg);
    logic [SW-1:0] m;
    m = neg ? (SW'(q) + SW'(rnz)) : SW'(q);
    return apply_sign(m, neg) >>> GAIN_FRAC_BITS;
  endfunction

  logic signed [SW-1:0] p_c, inc_c, integ_sum, y_sum;

  assign p_c       = apply_sign({{(SW-PW-OUT_FRAC){1'b0}}, mul_p, {OUT_FRAC{1'b0}}}, err_neg)
                     >>> GAIN_FRAC_BITS;
  assign inc_c     = floor_quo(div_q, div_rnz, err_neg);
  assign integ_sum = SW'(integrator) + inc_c;
  assign y_sum     = p_term - d_term + SW'(integrator);

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= IDLE;
      prop_gain    <= '0;
      integ_gain   <= '0;
      deriv_gain   <= '0;
      period       <= PERIOD_RESET;
      start_output <= '0;
      held_output  <= '0;
      integrator   <= '0;
      prev_sample  <= '0;
      prev_time    <= '0;
      primed       <= 1'b0;
      mul_go       <= 1'b0;
      div_go       <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      mul_go <= 1'b0;
      div_go <= 1'b0;
      if (st == DONE && (!result.valid || result.ready)) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end

      if (wr_en) begin
        case (wr_index)
          REG_PROP_GAIN:  prop_gain  <= wr_data[CFG_W-1:0];
          REG_INTEG_GAIN: integ_gain <= wr_data[CFG_W-1:0];
          REG_DERIV_GAIN: deriv_gain <= wr_data[CFG_W-1:0];
          REG_PERIOD:     period     <= wr_data[CFG_W-1:0];
          REG_START_OUT: begin
            start_output <= wr_data;
            if (!primed) begin
              held_output <= $signed(wr_data);
              integrator  <= INTEG_W'($signed(wr_data));
            end
          end
          default: ;
        endcase
      end

      case (st)
        IDLE: begin
          if (item.valid) begin
            if (el_c < period) begin
              p_term   <= SW'(held_output);
              d_term   <= '0;
              upd_flag <= 1'b0;
              st       <= DONE;
            end else begin
              err_neg <= err_c[S];
              err_mag <= err_c[S] ? -err_c : err_c;
              dm_neg  <= dm_c[S];
              dm_mag  <= dm_c[S] ? -dm_c : dm_c;
              elapsed <= el_c;
              now_t   <= item.time_ms;
              meas    <= item.sample;
              mul_a   <= AW'(err_c[S] ? -err_c : err_c);
              mul_b   <= prop_gain;
              mul_go  <= 1'b1;
              st      <= P_MUL;
            end
          end
        end
        P_MUL: if (mul_done) begin
          p_term <= p_c;
          mul_a  <= AW'(err_mag);
          mul_b  <= integ_gain;
          mul_go <= 1'b1;
          st     <= I_MUL1;
        end
        I_MUL1: if (mul_done) begin
          mul_a  <= mul_p[AW-1:0];
          mul_b  <= elapsed;
          mul_go <= 1'b1;
          st     <= I_MUL2;
        end
        I_MUL2: if (mul_done) begin
          div_n  <= {mul_p, {OUT_FRAC{1'b0}}};
          div_d  <= MS_PER_S;
          div_go <= 1'b1;
          st     <= I_DIV;
        end
        I_DIV: if (div_done) begin
          if (integ_sum > I_HI)      integrator <= I_HI[INTEG_W-1:0];
          else if (integ_sum < I_LO) integrator <= I_LO[INTEG_W-1:0];
          else                       integrator <= integ_sum[INTEG_W-1:0];
          mul_a  <= AW'(dm_mag);
          mul_b  <= deriv_gain;
          mul_go <= 1'b1;
          st     <= D_MUL1;
        end
        D_MUL1: if (mul_done) begin
          mul_a  <= mul_p[AW-1:0];
          mul_b  <= MS_PER_S;
          mul_go <= 1'b1;
          st     <= D_MUL2;
        end
        D_MUL2: if (mul_done) begin
          // zero elapsed only with a zero period: derivative dropped
          if (elapsed == '0) begin
            d_term <= '0;
            st     <= SUM;
          end else begin
            div_n  <= {mul_p, {OUT_FRAC{1'b0}}};
            div_d  <= elapsed;
            div_go <= 1'b1;
            st     <= D_DIV;
          end
        end
        D_DIV: if (div_done) begin
          d_term <= floor_quo(div_q, div_rnz, dm_neg);
          st     <= SUM;
        end
        SUM: begin
          if (y_sum > O_HI)      p_term <= O_HI;
          else if (y_sum < O_LO) p_term <= O_LO;
          else                   p_term <= y_sum;
          d_term      <= '0;
          upd_flag    <= 1'b1;
          prev_time   <= now_t;
          prev_sample <= meas;
          primed      <= 1'b1;
          st          <= DONE;
        end
        DONE: begin
          // p_term holds the final value here; d_term is zero
          if (!result.valid || result.ready) begin
            out_drive    <= p_term[DATA_W-1:0];
            out_updated  <= upd_flag;
            held_output  <= p_term[DATA_W-1:0];
            st           <= IDLE;
          end
        end
        default: st <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
